FILE: sv/bcdalu_pkg.sv
// ----------------------------------------------------------------------------
// bcdalu_pkg
// Operation codes and BCD correction constants for the add/subtract ALU.
// ----------------------------------------------------------------------------
package bcdalu_pkg;

    typedef enum logic [0:0] {
        OP_ADC = 1'b0,
        OP_SBC = 1'b1
    } t_opcode;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned SIGN_BIT = DATA_W - 1;

    // low digit of an add at or above this wants the +6 fix
    localparam logic [NIB_W:0]    LO_LIMIT    = 5'h0A;
    localparam logic [NIB_W-1:0]  DIGIT_ADJ   = 4'h6;
    // a negative digit of a subtract: +16 then -6, within the nibble
    localparam logic [NIB_W-1:0]  DIGIT_BORROW_ADJ = 4'hA;
    localparam logic [DATA_W:0]   HI_LIMIT    = 9'h0A0;
    localparam logic [DATA_W+1:0] HI_ADJ      = 10'h060;

endpackage

FILE: sv/bcd_binary_add_subtract_alu.sv
// ----------------------------------------------------------------------------
// bcd_binary_add_subtract_alu
// 8-bit add-with-carry / subtract-with-borrow ALU with packed BCD mode.
// ----------------------------------------------------------------------------
// A three-stage pipeline: an operation transferred with start passes through
// stages 1, 2 and 3 to the result ports, where o_valid flags it for one
// cycle. One operation may be transferred every cycle; busy stays low, since
// nothing in the pipeline waits. The receiver cannot stall and must take each
// result in its strobe cycle. Stage one forms the binary sum and the raw low
// digit, stage two corrects the low digit and forms the high digit and the
// N, Z and V flags, stage three corrects the high digit and selects the
// decimal or binary accumulator and carry. N, Z and V always describe the
// binary sum or difference, also in decimal mode.
module bcd_binary_add_subtract_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_opcode,
    input  logic [7:0] i_accumulator_in,
    input  logic [7:0] i_operand,
    input  logic       i_carry_in,
    input  logic       i_decimal_mode,
    output logic       o_valid,
    output logic [7:0] o_accumulator_out,
    output logic       o_carry_out,
    output logic       o_zero_flag,
    output logic       o_negative_flag,
    output logic       o_overflow_flag
);
    import bcdalu_pkg::*;

    logic in_xfer;

    // ---- stage 1 ----
    logic              r_s1_valid;
    logic              r_s1_sub;
    logic              r_s1_dec;
    logic [DATA_W:0]   r_s1_bin;
    logic              r_s1_a_msb;
    logic              r_s1_addend_msb;
    logic [NIB_W:0]    r_s1_lo_add;
    logic [NIB_W:0]    r_s1_lo_sub;
    logic [NIB_W-1:0]  r_s1_a_hi;
    logic [NIB_W-1:0]  r_s1_v_hi;

    logic              n_s1_sub;
    logic [DATA_W-1:0] n_s1_addend;
    logic [DATA_W:0]   n_s1_bin;
    logic [NIB_W:0]    n_s1_lo_add;
    logic [NIB_W:0]    n_s1_lo_sub;

    // ---- stage 2 ----
    logic              r_s2_valid;
    logic              r_s2_sub;
    logic              r_s2_dec;
    logic [DATA_W:0]   r_s2_bin;
    logic              r_s2_z;
    logic              r_s2_n;
    logic              r_s2_v;
    logic [DATA_W:0]   r_s2_sum;
    logic [NIB_W-1:0]  r_s2_lo_u;
    logic [NIB_W:0]    r_s2_hi;

    logic [NIB_W:0]    n_s2_lo_fix;
    logic [DATA_W:0]   n_s2_sum;
    logic              n_s2_lo_neg;
    logic [NIB_W-1:0]  n_s2_lo_u;
    logic [NIB_W:0]    n_s2_hi;

    // ---- stage 3 (output) ----
    logic              r_o_valid;
    logic              r_o_dec;
    logic [DATA_W-1:0] r_o_acc;
    logic              r_o_c;
    logic              r_o_z;
    logic              r_o_n;
    logic              r_o_v;

    logic [DATA_W+1:0] n_o_sum;
    logic [NIB_W-1:0]  n_o_hi_u;
    logic [DATA_W-1:0] n_o_acc;
    logic              n_o_c;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    // stage 1: binary sum and raw low digits
    always_comb begin
        n_s1_sub    = (t_opcode'(i_opcode) == OP_SBC);
        n_s1_addend = n_s1_sub ? ~i_operand : i_operand;
        n_s1_bin    = {1'b0, i_accumulator_in} + {1'b0, n_s1_addend}
                    + {{DATA_W{1'b0}}, i_carry_in};
        n_s1_lo_add = {1'b0, i_accumulator_in[NIB_W-1:0]}
                    + {1'b0, i_operand[NIB_W-1:0]}
                    + {{NIB_W{1'b0}}, i_carry_in};
        // two's complement in five bits, bit 4 set when negative
        n_s1_lo_sub = {1'b0, i_accumulator_in[NIB_W-1:0]}
                    - {1'b0, i_operand[NIB_W-1:0]}
                    - {{NIB_W{1'b0}}, ~i_carry_in};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_xfer;
        end
        r_s1_sub        <= n_s1_sub;
        r_s1_dec        <= i_decimal_mode;
        r_s1_bin        <= n_s1_bin;
        r_s1_a_msb      <= i_accumulator_in[SIGN_BIT];
        r_s1_addend_msb <= n_s1_addend[SIGN_BIT];
        r_s1_lo_add     <= n_s1_lo_add;
        r_s1_lo_sub     <= n_s1_lo_sub;
        r_s1_a_hi       <= i_accumulator_in[DATA_W-1:NIB_W];
        r_s1_v_hi       <= i_operand[DATA_W-1:NIB_W];
    end

    // stage 2: low digit correction, high digit
    always_comb begin
        n_s2_lo_fix = (r_s1_lo_add >= LO_LIMIT)
                    ? {1'b1, r_s1_lo_add[NIB_W-1:0] + DIGIT_ADJ}
                    : r_s1_lo_add;
        n_s2_sum    = {1'b0, r_s1_a_hi, {NIB_W{1'b0}}}
                    + {1'b0, r_s1_v_hi, {NIB_W{1'b0}}}
                    + {{(DATA_W-NIB_W){1'b0}}, n_s2_lo_fix};
        n_s2_lo_neg = r_s1_lo_sub[NIB_W];
        n_s2_lo_u   = n_s2_lo_neg ? r_s1_lo_sub[NIB_W-1:0] + DIGIT_BORROW_ADJ
                                  : r_s1_lo_sub[NIB_W-1:0];
        n_s2_hi     = {1'b0, r_s1_a_hi} - {1'b0, r_s1_v_hi}
                    - {{NIB_W{1'b0}}, n_s2_lo_neg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_sub  <= r_s1_sub;
        r_s2_dec  <= r_s1_dec;
        r_s2_bin  <= r_s1_bin;
        r_s2_z    <= (r_s1_bin[DATA_W-1:0] == '0);
        r_s2_n    <= r_s1_bin[SIGN_BIT];
        r_s2_v    <= (r_s1_a_msb ^ r_s1_bin[SIGN_BIT])
                   & (r_s1_addend_msb ^ r_s1_bin[SIGN_BIT]);
        r_s2_sum  <= n_s2_sum;
        r_s2_lo_u <= n_s2_lo_u;
        r_s2_hi   <= n_s2_hi;
    end

    // stage 3: high digit correction and result select
    always_comb begin
        n_o_sum  = (r_s2_sum >= HI_LIMIT) ? {1'b0, r_s2_sum} + HI_ADJ
                                          : {1'b0, r_s2_sum};
        n_o_hi_u = r_s2_hi[NIB_W] ? r_s2_hi[NIB_W-1:0] + DIGIT_BORROW_ADJ
                                  : r_s2_hi[NIB_W-1:0];
        if (!r_s2_dec) begin
            n_o_acc = r_s2_bin[DATA_W-1:0];
            n_o_c   = r_s2_bin[DATA_W];
        end else if (r_s2_sub) begin
            n_o_acc = {n_o_hi_u, r_s2_lo_u};
            n_o_c   = !r_s2_hi[NIB_W];
        end else begin
            n_o_acc = n_o_sum[DATA_W-1:0];
            n_o_c   = |n_o_sum[DATA_W+1:DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s2_valid;
        end
        r_o_dec <= r_s2_dec;
        r_o_acc <= n_o_acc;
        r_o_c   <= n_o_c;
        r_o_z   <= r_s2_z;
        r_o_n   <= r_s2_n;
        r_o_v   <= r_s2_v;
    end

    assign o_valid           = r_o_valid;
    assign o_accumulator_out = r_o_acc;
    assign o_carry_out       = r_o_c;
    assign o_zero_flag       = r_o_z;
    assign o_negative_flag   = r_o_n;
    assign o_overflow_flag   = r_o_v;

    // every transfer is answered by a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##3 o_valid)
        else $error("result strobe missing three cycles after transfer");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result strobe without a matching transfer");

    // in binary mode Z and N agree with the accumulator itself
    a_bin_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_o_dec) |->
            (o_zero_flag == (o_accumulator_out == '0))
            && (o_negative_flag == o_accumulator_out[SIGN_BIT]))
        else $error("binary flags disagree with accumulator");

endmodule

FILE: tb/bcd_binary_add_subtract_alu_tb.sv
// ----------------------------------------------------------------------------
// bcd_binary_add_subtract_alu_tb
// Self-checking bench for the binary/BCD add and subtract ALU. Operations are
// sent in random bursts. Each transfer is scored against a behavioural model
// of the ALU, and every o_valid strobe is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bcd_binary_add_subtract_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdalu_pkg::*;

    localparam int PIPE_DEPTH  = 3;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic              carry;
        logic              zero;
        logic              neg;
        logic              ovf;
    } t_alu_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [DATA_W-1:0] i_accumulator_in;
    logic [DATA_W-1:0] i_operand;
    logic              i_carry_in;
    logic              i_decimal_mode;
    logic              o_valid;
    logic [DATA_W-1:0] o_accumulator_out;
    logic              o_carry_out;
    logic              o_zero_flag;
    logic              o_negative_flag;
    logic              o_overflow_flag;

    t_alu_result expected_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;

    bcd_binary_add_subtract_alu i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_accumulator_in  (i_accumulator_in),
        .i_operand         (i_operand),
        .i_carry_in        (i_carry_in),
        .i_decimal_mode    (i_decimal_mode),
        .o_valid           (o_valid),
        .o_accumulator_out (o_accumulator_out),
        .o_carry_out       (o_carry_out),
        .o_zero_flag       (o_zero_flag),
        .o_negative_flag   (o_negative_flag),
        .o_overflow_flag   (o_overflow_flag)
    );

    always #5 i_clk = ~i_clk;

    // N, Z and V always follow the binary sum, even in decimal mode
    function automatic t_alu_result predict_alu_result(t_opcode op, logic [7:0] a,
                                                       logic [7:0] b, logic cin,
                                                       logic dec);
        t_alu_result res;
        logic [7:0]  addend;
        logic [8:0]  bin;
        int          lo;
        int          hi;
        int          sum;
        int          a_lo;
        int          a_hi;
        int          b_lo;
        int          b_hi;
        a_lo   = int'(a[3:0]);
        a_hi   = int'(a[7:4]);
        b_lo   = int'(b[3:0]);
        b_hi   = int'(b[7:4]);
        addend = (op == OP_SBC) ? ~b : b;
        bin    = {1'b0, a} + {1'b0, addend} + {8'd0, cin};
        res.zero = (bin[7:0] == 8'd0);
        res.neg  = bin[SIGN_BIT];
        res.ovf  = ((a ^ bin[7:0]) & (addend ^ bin[7:0]) & 8'h80) != 8'd0;
        if (!dec) begin
            res.acc   = bin[7:0];
            res.carry = bin[8];
        end else if (op == OP_ADC) begin
            lo = a_lo + b_lo + int'(cin);
            if (lo >= int'(LO_LIMIT))
                lo = ((lo + int'(DIGIT_ADJ)) & 15) + 16;
            sum = (a_hi << 4) + (b_hi << 4) + lo;
            if (sum >= int'(HI_LIMIT))
                sum = sum + int'(HI_ADJ);
            res.acc   = sum[7:0];
            res.carry = (sum >= 256);
        end else begin
            lo = a_lo - b_lo - (cin ? 0 : 1);
            hi = a_hi - b_hi;
            if (lo < 0) begin
                lo = (lo + int'(DIGIT_BORROW_ADJ)) & 15;
                hi = hi - 1;
            end
            if (hi < 0) begin
                hi        = (hi + int'(DIGIT_BORROW_ADJ)) & 15;
                res.carry = 1'b0;
            end else begin
                res.carry = 1'b1;
            end
            res.acc = {hi[3:0], lo[3:0]};
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge that takes the transfer
    task automatic issue_op(t_opcode op, logic [7:0] a, logic [7:0] b, logic cin,
                            logic dec);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        i_opcode         <= op;
        i_accumulator_in <= a;
        i_operand        <= b;
        i_carry_in       <= cin;
        i_decimal_mode   <= dec;
        start            <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        expected_results.push_back(predict_alu_result(op, a, b, cin, dec));
    endtask

    function automatic logic [7:0] rand_bcd_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 9));
        lo = 4'($urandom_range(0, 9));
        return {hi, lo};
    endfunction

    task automatic test_binary_extremes();
        issue_op(OP_ADC, 8'h00, 8'h00, 1'b0, 1'b0);
        issue_op(OP_ADC, 8'hFF, 8'h01, 1'b0, 1'b0);
        issue_op(OP_ADC, 8'h7F, 8'h01, 1'b0, 1'b0);
        issue_op(OP_ADC, 8'h80, 8'h80, 1'b0, 1'b0);
        issue_op(OP_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0);
        issue_op(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b0);
        issue_op(OP_SBC, 8'h80, 8'h01, 1'b1, 1'b0);
        issue_op(OP_SBC, 8'h50, 8'hF0, 1'b0, 1'b0);
        issue_op(OP_SBC, 8'hFF, 8'hFF, 1'b1, 1'b0);
        issue_op(OP_SBC, 8'h00, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_decimal_cases();
        issue_op(OP_ADC, 8'h09, 8'h01, 1'b0, 1'b1);
        issue_op(OP_ADC, 8'h99, 8'h01, 1'b0, 1'b1);
        issue_op(OP_ADC, 8'h58, 8'h46, 1'b1, 1'b1);
        issue_op(OP_ADC, 8'h79, 8'h00, 1'b1, 1'b1);   // BCD 80, but N stays clear from the binary sum 7A
        issue_op(OP_ADC, 8'h00, 8'h00, 1'b0, 1'b1);
        // non-BCD digits still get the fix-up
        issue_op(OP_ADC, 8'h0F, 8'h0F, 1'b1, 1'b1);
        issue_op(OP_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'h46, 8'h12, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'h40, 8'h13, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'h32, 8'h02, 1'b0, 1'b1);
        issue_op(OP_SBC, 8'h0A, 8'h0F, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'hFF, 8'h00, 1'b1, 1'b1);
        issue_op(OP_SBC, 8'h00, 8'hFF, 1'b0, 1'b1);
    endtask

    // mostly well-formed BCD operands; some raw bytes mixed in
    task automatic test_random_decimal(int count);
        t_opcode    op;
        logic [7:0] a;
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            op = t_opcode'($urandom_range(0, 1));
            a  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : rand_bcd_byte();
            b  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : rand_bcd_byte();
            issue_op(op, a, b, 1'($urandom), 1'b1);
        end
    endtask

    task automatic test_random_mixed(int count);
        for (int k = 0; k < count; k++) begin
            // a back-to-back stretch in the middle
            gaps_on = !(k >= count / 3 && k < count / 2);
            issue_op(t_opcode'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_alu_result exp_res;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result acc=%h c=%b z=%b n=%b v=%b", $time,
                         o_accumulator_out, o_carry_out, o_zero_flag, o_negative_flag,
                         o_overflow_flag);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_accumulator_out !== exp_res.acc) begin
                    $display("%0t: accumulator expected %h actual %h", $time,
                             exp_res.acc, o_accumulator_out);
                    error_count++;
                end
                if (o_carry_out !== exp_res.carry) begin
                    $display("%0t: carry expected %b actual %b", $time,
                             exp_res.carry, o_carry_out);
                    error_count++;
                end
                if (o_zero_flag !== exp_res.zero) begin
                    $display("%0t: zero expected %b actual %b", $time,
                             exp_res.zero, o_zero_flag);
                    error_count++;
                end
                if (o_negative_flag !== exp_res.neg) begin
                    $display("%0t: negative expected %b actual %b", $time,
                             exp_res.neg, o_negative_flag);
                    error_count++;
                end
                if (o_overflow_flag !== exp_res.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             exp_res.ovf, o_overflow_flag);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_opcode         <= OP_ADC;
        i_accumulator_in <= 8'd0;
        i_operand        <= 8'd0;
        i_carry_in       <= 1'b0;
        i_decimal_mode   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_binary_extremes();
        test_decimal_cases();
        test_random_decimal(575);
        test_random_mixed(575);

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
